// ===== design/six_channel_servo_slew_limiter_top_macros.svh =====
// Assertion macros used by the slew limiter checker.
`ifndef SIX_CHANNEL_SERVO_SLEW_LIMITER_TOP_MACROS_SVH
`define SIX_CHANNEL_SERVO_SLEW_LIMITER_TOP_MACROS_SVH

// Check a property outside reset.
`define SSLIM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a property at every edge, reset included.
`define SSLIM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== design/sslim_pkg.sv =====
// Shared types and constants of the servo slew limiter.
package sslim_pkg;

  localparam int NUM_DOTS  = 6;
  localparam int CFG_W     = 48;
  localparam int CFG_IDX_W = 1;

  localparam logic [1:0] REQ_TICK    = 2'd0;
  localparam logic [1:0] REQ_LOAD    = 2'd1;
  localparam logic [1:0] REQ_ENABLE  = 2'd2;
  localparam logic [1:0] REQ_DISABLE = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_RAISED  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOWERED = 1'd1;

  localparam logic [CFG_W-1:0] RAISED_RESET  = 48'd44152937523240;
  localparam logic [CFG_W-1:0] LOWERED_RESET = 48'd22076468761620;

  localparam logic [7:0] DEG_MAX   = 8'd180;
  localparam logic [7:0] DEG_RESET = 8'd20;
  localparam logic [6:0] SPEED_MAX = 7'd100;

  typedef struct packed {
    logic [1:0] req_type;
    logic [5:0] cell_bits;
  } op_t;

  typedef struct packed {
    logic [7:0] deg;
    logic       off_target;
  } lane_stat_t;

endpackage

// ===== design/sslim_if.sv =====
// Request and result channel interfaces of the servo slew limiter.
interface sslim_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [5:0] cell_bits;
  logic [6:0] speed_percent;

  modport source(output valid, output req_type, output cell_bits, output speed_percent,
                 input ready);
  modport sink(input valid, input req_type, input cell_bits, input speed_percent,
               output ready);
endinterface

interface sslim_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] angle_dot1;
  logic [7:0] angle_dot2;
  logic [7:0] angle_dot3;
  logic [7:0] angle_dot4;
  logic [7:0] angle_dot5;
  logic [7:0] angle_dot6;
  logic       moving;
  logic       motion_enabled;

  modport source(output valid, output angle_dot1, output angle_dot2, output angle_dot3,
                 output angle_dot4, output angle_dot5, output angle_dot6,
                 output moving, output motion_enabled, input ready);
  modport sink(input valid, input angle_dot1, input angle_dot2, input angle_dot3,
               input angle_dot4, input angle_dot5, input angle_dot6,
               input moving, input motion_enabled, output ready);
endinterface

// ===== design/six_channel_servo_slew_limiter_top.sv =====
// Top level of the six-lane servo slew limiter.
//
//   channel | dir | handshake           | payload
//   req     | in  | valid/ready         | req_type, cell_bits, speed_percent
//   res     | out | valid/ready         | angle_dot1..6, moving, motion_enabled
//   cfg     | in  | cfg_we (no ready)   | cfg_index, cfg_data
//
// One item per cycle while the result side is not stalled; a request goes from the step
// register through the lane update into the result register.
// All lanes update in parallel; the step multiply sits in its own stage.
// Synchronous reset drops valids and loads the reset angles, pattern, enable and registers.
// A stalled result holds; one more request is taken into the step stage meanwhile.
module six_channel_servo_slew_limiter_top import sslim_pkg::*; #(
  parameter int LANES     = 6,
  parameter int FRAC_BITS = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  sslim_req_if.sink            req,
  sslim_res_if.source          res
);

  localparam int STEP_W = 7 + FRAC_BITS;

  logic [CFG_W-1:0]  raised;
  logic [CFG_W-1:0]  lowered;
  logic              s1_valid;
  op_t               s1_op;
  logic [STEP_W-1:0] step;
  logic [5:0]        pattern;
  logic [5:0]        pattern_next;
  logic              servo_enabled;
  logic              servo_enabled_next;
  logic              advance;
  logic              fire;
  logic              take;
  logic              tick;
  logic              any_moving;
  lane_stat_t        lane_stat [LANES];
  logic [7:0]        dot_deg [NUM_DOTS];
  logic              out_valid;
  logic [7:0]        out_deg [NUM_DOTS];
  logic              out_moving;
  logic              out_enabled;

  assign advance   = !out_valid || res.ready;
  assign fire      = s1_valid && advance;
  assign req.ready = !s1_valid || advance;
  assign take      = req.valid && req.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      raised  <= RAISED_RESET;
      lowered <= LOWERED_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_RAISED:  raised <= cfg_data;
        CFG_LOWERED: lowered <= cfg_data;
        default: ;
      endcase
    end
  end

  // step stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (take) begin
      s1_valid <= 1'b1;
    end else if (fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_op.req_type  <= req.req_type;
      s1_op.cell_bits <= req.cell_bits;
    end
  end

  sslim_step #(.FRAC_BITS(FRAC_BITS)) u_step (
    .clk  (clk),
    .load (take),
    .speed(req.speed_percent),
    .step (step)
  );

  // command decode in the update stage
  always_comb begin
    pattern_next       = pattern;
    servo_enabled_next = servo_enabled;
    if (fire) begin
      case (s1_op.req_type)
        REQ_LOAD:    pattern_next = s1_op.cell_bits;
        REQ_ENABLE:  servo_enabled_next = 1'b1;
        REQ_DISABLE: servo_enabled_next = 1'b0;
        default: ;
      endcase
    end
  end

  assign tick = fire && (s1_op.req_type == REQ_TICK) && servo_enabled;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern       <= '0;
      servo_enabled <= 1'b1;
    end else begin
      pattern       <= pattern_next;
      servo_enabled <= servo_enabled_next;
    end
  end

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    logic [7:0] tgt_deg;
    if (i < NUM_DOTS) begin : g_dot
      logic [7:0] raw;
      assign raw     = pattern_next[i] ? raised[8*i +: 8] : lowered[8*i +: 8];
      assign tgt_deg = (raw > DEG_MAX) ? DEG_MAX : raw;
    end else begin : g_extra
      assign tgt_deg = '0;
    end

    sslim_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
      .clk    (clk),
      .rst    (rst),
      .advance(tick),
      .step   (step),
      .target ({tgt_deg, {FRAC_BITS{1'b0}}}),
      .stat   (lane_stat[i])
    );
  end

  // merge lanes
  always_comb begin
    any_moving = 1'b0;
    for (int i = 0; i < LANES; i++) begin
      any_moving = any_moving | lane_stat[i].off_target;
    end
  end

  for (genvar j = 0; j < NUM_DOTS; j++) begin : g_out
    if (j < LANES) begin : g_used
      assign dot_deg[j] = lane_stat[j].deg;
    end else begin : g_absent
      assign dot_deg[j] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_deg     <= dot_deg;
      out_moving  <= any_moving;
      out_enabled <= servo_enabled_next;
    end
  end

  assign res.valid          = out_valid;
  assign res.angle_dot1     = out_deg[0];
  assign res.angle_dot2     = out_deg[1];
  assign res.angle_dot3     = out_deg[2];
  assign res.angle_dot4     = out_deg[3];
  assign res.angle_dot5     = out_deg[4];
  assign res.angle_dot6     = out_deg[5];
  assign res.moving         = out_moving;
  assign res.motion_enabled = out_enabled;

endmodule

// ===== design/sslim_step.sv =====
// Step size stage: speed percent to a fixed-point step, divided by 100 via reciprocal.
module sslim_step import sslim_pkg::*; #(
  parameter int FRAC_BITS = 8
) (
  input  logic                 clk,
  input  logic                 load,
  input  logic [6:0]           speed,
  output logic [FRAC_BITS+6:0] step
);

  // numerator (100 + 89*s) << FRAC_BITS stays below 2^NUM_W
  localparam int NUM_W  = 14 + FRAC_BITS;
  localparam int SHIFT  = NUM_W + 7;
  localparam int PROD_W = NUM_W + SHIFT - 6;
  localparam int STEP_W = 7 + FRAC_BITS;
  localparam logic [63:0] RECIP = ((64'd1 << SHIFT) + 64'd99) / 64'd100;
  localparam logic [PROD_W-1:0] BASE_C  = PROD_W'(64'd100 * (64'd1 << FRAC_BITS) * RECIP);
  localparam logic [PROD_W-1:0] SLOPE_C = PROD_W'(64'd89 * (64'd1 << FRAC_BITS) * RECIP);

  logic [6:0]        speed_sat;
  logic [PROD_W-1:0] prod;

  assign speed_sat = (speed > SPEED_MAX) ? SPEED_MAX : speed;
  assign prod      = BASE_C + PROD_W'(speed_sat) * SLOPE_C;

  always_ff @(posedge clk) begin
    if (load) begin
      step <= prod[SHIFT +: STEP_W];
    end
  end

endmodule

// ===== design/sslim_lane.sv =====
// One servo lane: angle register, slew toward target with clamp, rounding.
module sslim_lane import sslim_pkg::*; #(
  parameter int FRAC_BITS = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 advance,
  input  logic [FRAC_BITS+6:0] step,
  input  logic [FRAC_BITS+7:0] target,
  output lane_stat_t           stat
);

  localparam int AW = 8 + FRAC_BITS;

  logic [AW-1:0] angle;
  logic [AW-1:0] angle_next;
  logic [AW-1:0] moved;
  logic [AW:0]   up_sum;
  logic [AW-1:0] down_diff;
  logic [AW-1:0] step_ext;
  logic [AW:0]   round_sum;

  assign step_ext  = AW'(step);
  assign up_sum    = {1'b0, angle} + {1'b0, step_ext};
  assign down_diff = angle - target;

  always_comb begin
    if (angle < target) begin
      moved = (up_sum > {1'b0, target}) ? target : up_sum[AW-1:0];
    end else if (angle > target) begin
      moved = (down_diff > step_ext) ? angle - step_ext : target;
    end else begin
      moved = angle;
    end
  end

  assign angle_next = advance ? moved : angle;

  always_ff @(posedge clk) begin
    if (rst) begin
      angle <= {DEG_RESET, {FRAC_BITS{1'b0}}};
    end else begin
      angle <= angle_next;
    end
  end

  // round half up to whole degrees
  assign round_sum       = {1'b0, angle_next} + ((AW+1)'(1) << (FRAC_BITS - 1));
  assign stat.deg        = round_sum[FRAC_BITS +: 8];
  assign stat.off_target = (angle_next != target);

endmodule

// ===== design/sslim_chk.sv =====
// Port-level checker for the servo slew limiter, bound to the top level.
`include "six_channel_servo_slew_limiter_top_macros.svh"

module sslim_chk import sslim_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       res_valid,
  input logic       res_ready,
  input logic [7:0] dot1,
  input logic [7:0] dot2,
  input logic [7:0] dot3,
  input logic [7:0] dot4,
  input logic [7:0] dot5,
  input logic [7:0] dot6,
  input logic       moving,
  input logic       motion_enabled
);

  logic        stalled;
  logic [49:0] res_word;
  logic        dots_ok;

  assign stalled  = res_valid && !res_ready;
  assign res_word = {dot1, dot2, dot3, dot4, dot5, dot6, moving, motion_enabled};
  assign dots_ok  = dot1 <= DEG_MAX && dot2 <= DEG_MAX && dot3 <= DEG_MAX &&
                    dot4 <= DEG_MAX && dot5 <= DEG_MAX && dot6 <= DEG_MAX;

  `SSLIM_ASSERT_ALWAYS(a_reset_clears_res, rst |=> !res_valid, "result valid after reset")
  `SSLIM_ASSERT(a_res_hold, stalled |=> res_valid, "result dropped while stalled")
  `SSLIM_ASSERT(a_res_stable, stalled |=> $stable(res_word), "result changed while stalled")
  `SSLIM_ASSERT(a_deg_range, res_valid |-> dots_ok, "angle above full scale")

endmodule

bind six_channel_servo_slew_limiter_top sslim_chk u_sslim_chk (
  .clk           (clk),
  .rst           (rst),
  .res_valid     (res.valid),
  .res_ready     (res.ready),
  .dot1          (res.angle_dot1),
  .dot2          (res.angle_dot2),
  .dot3          (res.angle_dot3),
  .dot4          (res.angle_dot4),
  .dot5          (res.angle_dot5),
  .dot6          (res.angle_dot6),
  .moving        (res.moving),
  .motion_enabled(res.motion_enabled)
);
